### hw/rtl/snake_lattice_bond_term_generator_macros.svh
// Assertion macros for the snake lattice bond term generator.
// Included by the top level; no other dependencies.
`ifndef SNAKE_LATTICE_BOND_TERM_GENERATOR_MACROS_SVH
`define SNAKE_LATTICE_BOND_TERM_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SLBT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SLBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SLBT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SLBT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/slbt_pkg.sv
// Shared types and constants of the snake lattice bond term generator.
// Used by every module of the block; depends on nothing.
package slbt_pkg;

   localparam int MAX_SIDE = 256;
   localparam int SIDE_W = 9;
   localparam int COORD_W = 8;
   localparam int SITE_W = 16;
   localparam int COUNT_W = 17;
   localparam int NUM_BONDS = 4;
   localparam int NUM_SLOTS = 12;
   localparam int DIV_BITS = 4;

   localparam logic [1:0] OP_PLUS = 2'd0;
   localparam logic [1:0] OP_MINUS = 2'd1;
   localparam logic [1:0] OP_Z = 2'd2;

   localparam logic [2:0] CODE_J1 = 3'd0;
   localparam logic [2:0] CODE_JZ1 = 3'd1;
   localparam logic [2:0] CODE_J2 = 3'd2;
   localparam logic [2:0] CODE_JZ2 = 3'd3;
   localparam logic [2:0] CODE_PAIR = 3'd4;

   typedef enum logic [2:0] {
      REG_WIDTH = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_PERIODIC_X = 3'd2,
      REG_PERIODIC_Y = 3'd3,
      REG_ACTIVE_SITES = 3'd4,
      REG_COUPLING_ENABLE = 3'd5,
      REG_PAIRS_ONLY = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic periodic_x;
      logic periodic_y;
      logic [COUNT_W-1:0] site_count;
      logic [3:0] enable;
      logic pairs;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic [SITE_W-1:0] idx;
      logic [SITE_W-1:0] num;
      logic [SIDE_W-1:0] rem;
      logic [SITE_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic valid;
      logic [SITE_W-1:0] idx;
      logic [NUM_BONDS-1:0][SITE_W-1:0] nb;
      logic [NUM_SLOTS-1:0] mask;
      logic pairs;
   } bond_type;

endpackage

### hw/rtl/slbt_div_step.sv
// One registered stage of the restoring divider that splits the site index
// into column and row; four quotient bits per stage. Depends on slbt_pkg.
module slbt_div_step import slbt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic [SIDE_W-1:0] divisor,
   input  div_type stage_in,
   output div_type stage_out
);

   div_type stage_ff, stage_in_comb;

   always_comb begin
      logic [SIDE_W:0] trial;
      stage_in_comb = stage_in;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {stage_in_comb.rem, stage_in_comb.num[SITE_W-1]};
         stage_in_comb.num = {stage_in_comb.num[SITE_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            stage_in_comb.rem = SIDE_W'(trial - {1'b0, divisor});
            stage_in_comb.quo = {stage_in_comb.quo[SITE_W-2:0], 1'b1};
         end else begin
            stage_in_comb.rem = trial[SIDE_W-1:0];
            stage_in_comb.quo = {stage_in_comb.quo[SITE_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in_comb;
      end
   end

   assign stage_out = stage_ff;

endmodule

### hw/rtl/slbt_bond_calc.sv
// Two pipeline stages that turn column and row into the four neighbor
// indices and the mask of terms to emit. Depends on slbt_pkg.
module slbt_bond_calc import slbt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  cfg_type cfg,
   input  div_type div_in,
   output bond_type bond_out
);

   // Stage A registers.
   logic a_valid_ff;
   logic [SITE_W-1:0] a_idx_ff;
   logic [COORD_W-1:0] a_jy_ff, a_ya_ff;
   logic a_ix_odd_ff, a_xr_odd_ff, a_xl_odd_ff;
   logic [COUNT_W-1:0] a_pix_ff, a_pxr_ff, a_pxl_ff;
   logic a_up_ok_ff, a_right_ok_ff, a_left_ok_ff;

   logic [COORD_W-1:0] ix, r, hm1, wm1, jy, ya, xr, xl;
   logic up_ok, right_ok, left_ok;

   always_comb begin
      ix = div_in.quo[COORD_W-1:0];
      r = div_in.rem[COORD_W-1:0];
      hm1 = COORD_W'(cfg.height - SIDE_W'(1));
      wm1 = COORD_W'(cfg.width - SIDE_W'(1));
      jy = ix[0] ? COORD_W'(hm1 - r) : r;
      up_ok = (jy < hm1) || ((jy == hm1) && cfg.periodic_y);
      right_ok = (ix < wm1) || ((ix == wm1) && cfg.periodic_x);
      left_ok = (ix != '0) || cfg.periodic_x;
      ya = (jy == hm1) ? '0 : COORD_W'(jy + COORD_W'(1));
      xr = (ix == wm1) ? '0 : COORD_W'(ix + COORD_W'(1));
      xl = (ix == '0) ? wm1 : COORD_W'(ix - COORD_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= div_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_idx_ff <= div_in.idx;
         a_jy_ff <= jy;
         a_ya_ff <= ya;
         a_ix_odd_ff <= ix[0];
         a_xr_odd_ff <= xr[0];
         a_xl_odd_ff <= xl[0];
         a_pix_ff <= COUNT_W'(ix) * COUNT_W'(cfg.height);
         a_pxr_ff <= COUNT_W'(xr) * COUNT_W'(cfg.height);
         a_pxl_ff <= COUNT_W'(xl) * COUNT_W'(cfg.height);
         a_up_ok_ff <= up_ok;
         a_right_ok_ff <= right_ok;
         a_left_ok_ff <= left_ok;
      end
   end

   function automatic logic [COUNT_W-1:0] snake_at(
      input logic [COUNT_W-1:0] base,
      input logic odd,
      input logic [COORD_W-1:0] y,
      input logic [SIDE_W-1:0] h
   );
      logic [COUNT_W-1:0] res;
      if (odd) begin
         res = base + COUNT_W'(h) - COUNT_W'(1) - COUNT_W'(y);
      end else begin
         res = base + COUNT_W'(y);
      end
      return res;
   endfunction

   // Stage B: neighbor indices and the term slot mask.
   bond_type b_ff, b_in;

   always_comb begin
      logic [NUM_BONDS-1:0][COUNT_W-1:0] nb;
      logic [NUM_BONDS-1:0] keep;
      logic nn_en, diag_en, pm_en, z_en;
      nb[0] = snake_at(a_pix_ff, a_ix_odd_ff, a_ya_ff, cfg.height);
      nb[1] = snake_at(a_pxr_ff, a_xr_odd_ff, a_jy_ff, cfg.height);
      nb[2] = snake_at(a_pxl_ff, a_xl_odd_ff, a_ya_ff, cfg.height);
      nb[3] = snake_at(a_pxr_ff, a_xr_odd_ff, a_ya_ff, cfg.height);
      nn_en = cfg.pairs || cfg.enable[0] || cfg.enable[1];
      // A wrapped neighbor on a side of one is the site itself.
      diag_en = !cfg.pairs && (cfg.enable[2] || cfg.enable[3]) &&
                (cfg.width != SIDE_W'(1)) && (cfg.height != SIDE_W'(1)) && a_up_ok_ff;
      keep[0] = nn_en && a_up_ok_ff && (cfg.height != SIDE_W'(1)) &&
                (nb[0] < cfg.site_count);
      keep[1] = nn_en && a_right_ok_ff && (cfg.width != SIDE_W'(1)) &&
                (nb[1] < cfg.site_count);
      keep[2] = diag_en && a_left_ok_ff && (nb[2] < cfg.site_count);
      keep[3] = diag_en && a_right_ok_ff && (nb[3] < cfg.site_count);
      b_in.valid = a_valid_ff;
      b_in.idx = a_idx_ff;
      b_in.pairs = cfg.pairs;
      for (int k = 0; k < NUM_BONDS; k++) begin
         b_in.nb[k] = nb[k][SITE_W-1:0];
         pm_en = (k < 2) ? cfg.enable[0] : cfg.enable[2];
         z_en = (k < 2) ? cfg.enable[1] : cfg.enable[3];
         if (cfg.pairs) begin
            b_in.mask[3*k] = keep[k];
            b_in.mask[3*k+1] = 1'b0;
            b_in.mask[3*k+2] = 1'b0;
         end else begin
            b_in.mask[3*k] = keep[k] && pm_en;
            b_in.mask[3*k+1] = keep[k] && pm_en;
            b_in.mask[3*k+2] = keep[k] && z_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (enable) begin
         b_ff <= b_in;
      end
   end

   assign bond_out = b_ff;

endmodule

### hw/rtl/slbt_term_emit.sv
// Term sequencer: holds one site's bond list and sends one term per cycle
// through the output register. Depends on slbt_pkg.
module slbt_term_emit import slbt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  bond_type bond_in,
   output logic advance,
   output logic rsp_valid,
   output logic [2:0] rsp_coupling_code,
   output logic [1:0] rsp_first_operator,
   output logic [SITE_W-1:0] rsp_lower_site,
   output logic [1:0] rsp_second_operator,
   output logic [SITE_W-1:0] rsp_upper_site,
   output logic rsp_last_term
);

   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic [SITE_W-1:0] idx_ff;
   logic [NUM_BONDS-1:0][SITE_W-1:0] nb_ff;
   logic pairs_ff;

   logic [NUM_SLOTS-1:0] low_bit, rest;
   logic [1:0] bond_k, term_t;
   logic free, load;

   logic valid_ff;
   logic [2:0] code_ff;
   logic [1:0] op1_ff, op2_ff;
   logic [SITE_W-1:0] lo_ff, hi_ff;
   logic last_ff;

   always_comb begin
      low_bit = mask_ff & NUM_SLOTS'(~mask_ff + NUM_SLOTS'(1));
      rest = mask_ff & ~low_bit;
      bond_k = '0;
      term_t = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (low_bit[i]) begin
            bond_k = 2'(i / 3);
            term_t = 2'(i % 3);
         end
      end
      // The held list can be replaced once its final term goes out this cycle.
      free = (rest == '0);
      load = bond_in.valid && (bond_in.mask != '0) && free;
      advance = !bond_in.valid || (bond_in.mask == '0) || free;
      mask_in = load ? bond_in.mask : rest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         valid_ff <= (mask_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         idx_ff <= bond_in.idx;
         nb_ff <= bond_in.nb;
         pairs_ff <= bond_in.pairs;
      end
   end

   always_ff @(posedge clock) begin
      logic [SITE_W-1:0] other;
      other = nb_ff[bond_k];
      if (pairs_ff) begin
         code_ff <= CODE_PAIR;
         op1_ff <= OP_PLUS;
         op2_ff <= OP_PLUS;
      end else begin
         unique case (term_t)
            2'd0: begin
               code_ff <= bond_k[1] ? CODE_J2 : CODE_J1;
               op1_ff <= OP_PLUS;
               op2_ff <= OP_MINUS;
            end
            2'd1: begin
               code_ff <= bond_k[1] ? CODE_J2 : CODE_J1;
               op1_ff <= OP_MINUS;
               op2_ff <= OP_PLUS;
            end
            default: begin
               code_ff <= bond_k[1] ? CODE_JZ2 : CODE_JZ1;
               op1_ff <= OP_Z;
               op2_ff <= OP_Z;
            end
         endcase
      end
      lo_ff <= (idx_ff < other) ? idx_ff : other;
      hi_ff <= (idx_ff < other) ? other : idx_ff;
      last_ff <= (rest == '0);
   end

   assign rsp_valid = valid_ff;
   assign rsp_coupling_code = code_ff;
   assign rsp_first_operator = op1_ff;
   assign rsp_second_operator = op2_ff;
   assign rsp_lower_site = lo_ff;
   assign rsp_upper_site = hi_ff;
   assign rsp_last_term = last_ff;

endmodule

### hw/rtl/snake_lattice_bond_term_generator.sv
// Top level of the snake lattice bond term generator: registers, input
// stage, divider stages, bond calculation and term sequencer. Uses slbt_pkg.
//
//   channel   ports                       handshake
//   input     start, busy, req_site_index accepted when start and not busy
//   result    rsp_*                       rsp_valid strobe, one cycle each
//   config    csr_*                       csr_valid and csr_ready
//
// An item passes the input stage, four divider stages, two bond stages, the term
// sequencer and the output register before its first term leaves; busy holds it in place.
// Terms leave one per cycle, up to twelve per item, and the receiver cannot stall.
// Busy is high while a new list waits behind one with more than one term left.
// Reset clears the valid bits and the registers to their reset values.
module snake_lattice_bond_term_generator import slbt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [SITE_W-1:0] req_site_index,
   output logic rsp_valid,
   output logic [2:0] rsp_coupling_code,
   output logic [1:0] rsp_first_operator,
   output logic [SITE_W-1:0] rsp_lower_site,
   output logic [1:0] rsp_second_operator,
   output logic [SITE_W-1:0] rsp_upper_site,
   output logic rsp_last_term,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [COUNT_W-1:0] csr_data
);

`include "snake_lattice_bond_term_generator_macros.svh"

   logic [SIDE_W-1:0] width_ff, height_ff;
   logic periodic_x_ff, periodic_y_ff, pairs_only_ff;
   logic [COUNT_W-1:0] active_sites_ff, total_ff;
   logic [3:0] enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SIDE_W'(1);
         height_ff <= SIDE_W'(1);
         periodic_x_ff <= 1'b0;
         periodic_y_ff <= 1'b0;
         active_sites_ff <= '0;
         enable_ff <= '0;
         pairs_only_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WIDTH: width_ff <= csr_data[SIDE_W-1:0];
            REG_HEIGHT: height_ff <= csr_data[SIDE_W-1:0];
            REG_PERIODIC_X: periodic_x_ff <= csr_data[0];
            REG_PERIODIC_Y: periodic_y_ff <= csr_data[0];
            REG_ACTIVE_SITES: active_sites_ff <= csr_data;
            REG_COUPLING_ENABLE: enable_ff <= csr_data[3:0];
            REG_PAIRS_ONLY: pairs_only_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] res;
      if (v == '0) begin
         res = SIDE_W'(1);
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         res = SIDE_W'(MAX_SIDE);
      end else begin
         res = v;
      end
      return res;
   endfunction

   cfg_type cfg;

   always_comb begin
      cfg.width = eff_side(width_ff);
      cfg.height = eff_side(height_ff);
      cfg.periodic_x = periodic_x_ff;
      cfg.periodic_y = periodic_y_ff;
      cfg.site_count = pairs_only_ff ? total_ff : active_sites_ff;
      cfg.enable = enable_ff;
      cfg.pairs = pairs_only_ff;
   end

   // The site total is registered, so it follows the registers in the next cycle.
   always_ff @(posedge clock) begin
      total_ff <= COUNT_W'(cfg.width) * COUNT_W'(cfg.height);
   end

   logic advance;
   div_type s0_ff;
   logic in_range;

   assign busy = !advance;
   assign in_range = ({1'b0, req_site_index} < cfg.site_count) &&
                     ({1'b0, req_site_index} < total_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (advance) begin
         s0_ff.valid <= start && in_range;
      end
      if (advance) begin
         s0_ff.idx <= req_site_index;
         s0_ff.num <= req_site_index;
         s0_ff.rem <= '0;
         s0_ff.quo <= '0;
      end
   end

   div_type div1, div2, div3, div4;

   slbt_div_step u_div1 (.clock, .reset, .enable(advance), .divisor(cfg.height),
                         .stage_in(s0_ff), .stage_out(div1));
   slbt_div_step u_div2 (.clock, .reset, .enable(advance), .divisor(cfg.height),
                         .stage_in(div1), .stage_out(div2));
   slbt_div_step u_div3 (.clock, .reset, .enable(advance), .divisor(cfg.height),
                         .stage_in(div2), .stage_out(div3));
   slbt_div_step u_div4 (.clock, .reset, .enable(advance), .divisor(cfg.height),
                         .stage_in(div3), .stage_out(div4));

   bond_type bond;

   slbt_bond_calc u_bond (
      .clock, .reset, .enable(advance), .cfg, .div_in(div4), .bond_out(bond)
   );

   slbt_term_emit u_emit (
      .clock,
      .reset,
      .bond_in(bond),
      .advance,
      .rsp_valid,
      .rsp_coupling_code,
      .rsp_first_operator,
      .rsp_lower_site,
      .rsp_second_operator,
      .rsp_upper_site,
      .rsp_last_term
   );

   `SLBT_ASSERT_IMPLIES(a_sites_ordered, clock, reset, rsp_valid, rsp_lower_site <= rsp_upper_site)
   `SLBT_ASSERT_NEXT(a_stall_holds, clock, reset, busy, bond.valid && $stable(bond.idx))
   `SLBT_ASSERT_IMPLIES(a_busy_needs_terms, clock, reset, busy, bond.valid && bond.mask != '0)

endmodule

### verif/tb_snake_lattice_bond_term_generator.sv
// Testbench for the snake lattice bond term generator: random and directed sites over
// many lattice settings, each checked against a behavioral predictor of the bond terms.
// Depends on slbt_pkg and the snake_lattice_bond_term_generator top level.
module tb_snake_lattice_bond_term_generator;
   import slbt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0] code;
      logic [1:0] op_lo;
      logic [SITE_W-1:0] lo;
      logic [1:0] op_hi;
      logic [SITE_W-1:0] hi;
      logic last;
   } term_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [SITE_W-1:0] req_site_index = '0;
   logic rsp_valid;
   logic [2:0] rsp_coupling_code;
   logic [1:0] rsp_first_operator;
   logic [SITE_W-1:0] rsp_lower_site;
   logic [1:0] rsp_second_operator;
   logic [SITE_W-1:0] rsp_upper_site;
   logic rsp_last_term;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [COUNT_W-1:0] csr_data = '0;

   // Shadow copy of the block's registers.
   int unsigned cfg_width = 1, cfg_height = 1, cfg_px = 0, cfg_py = 0;
   int unsigned cfg_active = 0, cfg_enable = 0, cfg_pairs = 0;

   logic [SITE_W-1:0] site_queue[$];
   term_type bond_terms_due[$];
   term_type site_terms[$];
   int sites_sent = 0, terms_seen = 0, mismatches = 0, idle_left = 0;
   bit no_idle = 1'b0;

   snake_lattice_bond_term_generator uut (.*);

   always #10 clock = ~clock;

   function automatic int unsigned clamp_side(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
   endfunction

   function automatic int unsigned snake_pos(int unsigned ix, int unsigned jy, int unsigned h);
      if ((ix & 1) == 0) return ix * h + jy;
      return (ix + 1) * h - (jy + 1);
   endfunction

   function automatic void add_term(int unsigned code, int unsigned op_a, int unsigned a,
                                    int unsigned op_b, int unsigned b);
      term_type t;
      t.code = code[2:0];
      t.op_lo = op_a[1:0];
      t.op_hi = op_b[1:0];
      t.lo = (a < b) ? a[15:0] : b[15:0];
      t.hi = (a < b) ? b[15:0] : a[15:0];
      t.last = 1'b0;
      site_terms = {site_terms, t};
   endfunction

   function automatic void add_bond(bit pairs, bit diag, bit en_pm, bit en_z,
                                    int unsigned a, int unsigned b);
      int unsigned c_pm, c_z;
      c_pm = diag ? CODE_J2 : CODE_J1;
      c_z = diag ? CODE_JZ2 : CODE_JZ1;
      if (pairs) begin
         add_term(CODE_PAIR, OP_PLUS, a, OP_PLUS, b);
         return;
      end
      if (en_pm) begin
         add_term(c_pm, OP_PLUS, a, OP_MINUS, b);
         add_term(c_pm, OP_MINUS, a, OP_PLUS, b);
      end
      if (en_z) add_term(c_z, OP_Z, a, OP_Z, b);
   endfunction

   // Works out every term that one site causes and queues them in output order.
   function automatic void expand_site(logic [SITE_W-1:0] site);
      int unsigned w, h, total, idx, ns, ix, jy, r, ya, xr, nb;
      bit pairs, up_ok, right_ok, left_ok, en1, enz1, en2, enz2;
      w = clamp_side(cfg_width);
      h = clamp_side(cfg_height);
      total = w * h;
      idx = site;
      pairs = cfg_pairs[0];
      ns = pairs ? total : cfg_active;
      en1 = cfg_enable[0];
      enz1 = cfg_enable[1];
      en2 = cfg_enable[2];
      enz2 = cfg_enable[3];
      site_terms.delete();
      if (idx >= ns || idx >= total) return;
      ix = idx / h;
      r = idx % h;
      jy = ix[0] ? (h - 1 - r) : r;
      up_ok = (jy < h - 1) || (jy == h - 1 && cfg_py[0]);
      right_ok = (ix < w - 1) || (ix == w - 1 && cfg_px[0]);
      left_ok = (ix >= 1) || cfg_px[0];
      if (pairs || en1 || enz1) begin
         if (up_ok) begin
            ya = (jy + 1) % h;
            nb = snake_pos(ix, ya, h);
            if (nb < ns && ya != jy) add_bond(pairs, 1'b0, en1, enz1, idx, nb);
         end
         if (right_ok) begin
            xr = (ix + 1) % w;
            nb = snake_pos(xr, jy, h);
            if (nb < ns && xr != ix) add_bond(pairs, 1'b0, en1, enz1, idx, nb);
         end
      end
      if (!pairs && (en2 || enz2) && w > 1 && h > 1 && up_ok) begin
         ya = (jy + 1) % h;
         if (left_ok) begin
            nb = snake_pos((ix + w - 1) % w, ya, h);
            if (nb < ns) add_bond(1'b0, 1'b1, en2, enz2, idx, nb);
         end
         if (right_ok) begin
            nb = snake_pos((ix + 1) % w, ya, h);
            if (nb < ns) add_bond(1'b0, 1'b1, en2, enz2, idx, nb);
         end
      end
      if (site_terms.size() > 0) site_terms[site_terms.size() - 1].last = 1'b1;
      bond_terms_due = {bond_terms_due, site_terms};
   endfunction

   // Sender: an item is taken when start is high and busy is low.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expand_site(req_site_index);
            sites_sent++;
         end
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
               idle_left = $urandom_range(0, 4);
               start <= 1'b0;
            end else if (site_queue.size() > 0) begin
               req_site_index <= site_queue.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Receiver: every strobed term is compared with the oldest one due.
   always @(posedge clock) begin
      term_type e;
      if (!reset && rsp_valid) begin
         terms_seen++;
         if (bond_terms_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected term code %0d sites %0d-%0d", rsp_coupling_code,
                        rsp_lower_site, rsp_upper_site);
         end else begin
            e = bond_terms_due.pop_front();
            if (e.code !== rsp_coupling_code || e.op_lo !== rsp_first_operator ||
                e.lo !== rsp_lower_site || e.op_hi !== rsp_second_operator ||
                e.hi !== rsp_upper_site || e.last !== rsp_last_term) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: expected %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                           e.code, e.op_lo, e.lo, e.op_hi, e.hi, e.last, rsp_coupling_code,
                           rsp_first_operator, rsp_lower_site, rsp_second_operator,
                           rsp_upper_site, rsp_last_term);
            end
         end
      end
   end

   task automatic write_reg(reg_index_type r, int unsigned v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_data <= v[COUNT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (r)
         REG_WIDTH: cfg_width = v & 'h1ff;
         REG_HEIGHT: cfg_height = v & 'h1ff;
         REG_PERIODIC_X: cfg_px = v & 1;
         REG_PERIODIC_Y: cfg_py = v & 1;
         REG_ACTIVE_SITES: cfg_active = v & 'h1ffff;
         REG_COUPLING_ENABLE: cfg_enable = v & 'hf;
         REG_PAIRS_ONLY: cfg_pairs = v & 1;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_lattice(int unsigned w, int unsigned h, int unsigned px, int unsigned py,
                              int unsigned act, int unsigned en, int unsigned pairs);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_PERIODIC_X, px);
      write_reg(REG_PERIODIC_Y, py);
      write_reg(REG_ACTIVE_SITES, act);
      write_reg(REG_COUPLING_ENABLE, en);
      write_reg(REG_PAIRS_ONLY, pairs);
   endtask

   // Lets the queued items drain, then waits out any item that causes no term.
   task automatic drain();
      do @(negedge clock); while (site_queue.size() > 0 || start || bond_terms_due.size() > 0);
      repeat (30) @(negedge clock);
   endtask

   // Mostly sites inside the lattice, some anywhere in the 16-bit range.
   task automatic queue_random(int n);
      int unsigned total;
      logic [SITE_W-1:0] s;
      total = clamp_side(cfg_width) * clamp_side(cfg_height);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) s = SITE_W'($urandom_range(0, 65535));
         else s = SITE_W'($urandom_range(0, total - 1));
         site_queue = {site_queue, s};
      end
   endtask

   function automatic int unsigned pick_side();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 511;
         2: return 256;
         3: return $urandom_range(1, 511);
         default: return $urandom_range(1, 9);
      endcase
   endfunction

   initial begin
      int unsigned w, h, total;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset values: a one-site lattice with nothing active gives no terms.
      site_queue = {site_queue, SITE_W'(0)};
      site_queue = {site_queue, 16'hffff};
      drain();

      // Open 4x3 lattice, all couplings: corners, edges and out-of-range sites.
      set_lattice(4, 3, 0, 0, 12, 15, 0);
      for (int i = 0; i < 13; i++) site_queue = {site_queue, SITE_W'(i)};
      site_queue = {site_queue, 16'hffff};
      drain();

      // Periodic lattices with a side of 2 repeat wrapped diagonal bonds.
      set_lattice(2, 2, 1, 1, 4, 15, 0);
      for (int i = 0; i < 4; i++) site_queue = {site_queue, SITE_W'(i)};
      drain();

      // Pairs mode ignores the active count and the enables.
      set_lattice(5, 4, 1, 1, 0, 0, 1);
      for (int i = 0; i < 6; i++)
         site_queue = {site_queue, SITE_W'($urandom_range(0, 19))};
      drain();

      // Zero sides behave as 1; oversized sides clamp to the maximum.
      set_lattice(0, 0, 1, 1, 65536, 15, 0);
      site_queue = {site_queue, SITE_W'(0)};
      drain();
      set_lattice(511, 300, 1, 1, 65536, 15, 0);
      site_queue = {site_queue, SITE_W'(0)};
      site_queue = {site_queue, 16'hffff};
      site_queue = {site_queue, 16'h00ff};
      drain();

      for (int p = 0; p < 13; p++) begin
         w = pick_side();
         h = pick_side();
         total = clamp_side(w) * clamp_side(h);
         if (p == 12) no_idle = 1'b1;
         set_lattice(w, h, $urandom_range(0, 1), $urandom_range(0, 1),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                 : $urandom_range(0, total),
                     $urandom_range(0, 15), ($urandom_range(0, 4) == 0) ? 1 : 0);
         queue_random(27);
         drain();
      end

      $display("Checked %0d sites and %0d bond terms over varied lattice settings.",
               sites_sent, terms_seen);
      if (mismatches == 0) begin
         $display("PASS snake_lattice_bond_term_generator");
      end else begin
         $display("%0d mismatching terms.", mismatches);
         $display("FAIL snake_lattice_bond_term_generator");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Run timed out.");
      $display("FAIL snake_lattice_bond_term_generator");
      $finish;
   end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/slbt_pkg.sv
hw/rtl/slbt_div_step.sv
hw/rtl/slbt_bond_calc.sv
hw/rtl/slbt_term_emit.sv
hw/rtl/snake_lattice_bond_term_generator.sv
verif/tb_snake_lattice_bond_term_generator.sv
